// File: hdl/lsw_pkg.sv
// Shared types and constants of the load/store word unit.
// Holds the controller/datapath command and status structs; depends on nothing.
package lsw_pkg;

	localparam int MEM_BYTES = 65536;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int RF_DEPTH  = 16;
	localparam int RF_AW     = $clog2(RF_DEPTH);
	localparam int IN_W      = 88;
	localparam int OUT_W     = 72;

	localparam logic [1:0] OP_XFER = 2'd0;
	localparam logic [1:0] OP_WREG = 2'd1;
	localparam logic [1:0] OP_WMEM = 2'd2;

	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_GPIO = 2'd1;
	localparam logic [1:0] STAT_OOB  = 2'd2;

	localparam logic CFG_GPIO_LOW  = 1'b0;
	localparam logic CFG_GPIO_HIGH = 1'b1;

	// register file read select
	typedef enum logic [1:0] {RSEL_RM, RSEL_RS, RSEL_RN, RSEL_RD} rsel_t;
	// where the registered register file read lands
	typedef enum logic [2:0] {RCAP_NONE, RCAP_RM, RCAP_RS, RCAP_RN, RCAP_WORD} rcap_t;
	// register file write source
	typedef enum logic [1:0] {WSEL_PRE, WSEL_GPIO, WSEL_LOAD, WSEL_EA} wsel_t;
	// byte memory write source
	typedef enum logic [1:0] {MSEL_CLEAR, MSEL_PRE, MSEL_STORE} msel_t;

	typedef struct packed {
		logic              take_item;
		logic              rf_re;
		rsel_t             rf_rsel;
		rcap_t             rf_cap;
		logic              rf_we;
		wsel_t             rf_wsel;
		logic              calc_off;
		logic              calc_ea;
		logic              addr_from_ea;
		logic              addr_from_rn;
		logic              check;
		logic              mem_re;
		logic              mem_we;
		msel_t             mem_wsel;
		logic [1:0]        byte_sel;
		logic              byte_cap;
		logic [1:0]        cap_sel;
		logic              out_load;
		logic [MEM_AW-1:0] clr_addr;
	} lsw_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       pre;
		logic       is_load;
		logic       gpio;
		logic       oob;
		logic       rf_idx_ok;
		logic       mem_idx_ok;
	} lsw_stat_t;

endpackage

// File: hdl/lsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module lsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/lsw_datapath.sv
// Datapath of the load/store word unit: item registers, register file, byte
// memory, shifter, address adder, window and bounds checks, result register.
// Depends on lsw_pkg and lsw_ram.
module lsw_datapath
	import lsw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data,
	input  lsw_cmd_t         cmd,
	output lsw_stat_t        st,
	output logic [OUT_W-1:0] m_tdata
);

	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	function automatic logic [31:0] shift_op(logic [1:0] kind, logic [7:0] amt,
			logic [31:0] v);
		logic [4:0]  r;
		logic        big;
		logic [63:0] rot;
		logic [31:0] res;
		r   = amt[4:0];
		big = |amt[7:5];
		rot = {v, v} >> r;
		res = v;
		if (amt != 8'd0) begin
			case (kind)
				SH_LSL: res = big ? 32'd0 : (v << r);
				SH_LSR: res = big ? 32'd0 : (v >> r);
				SH_ASR: res = big ? {32{v[31]}} : 32'($signed(v) >>> r);
				SH_ROR: res = rot[31:0];
			endcase
		end
		return res;
	endfunction

	logic [1:0]  op_q;
	logic [31:0] ins_q;
	logic [15:0] idx_q;
	logic [31:0] data_q;
	logic [31:0] gpio_low_q, gpio_high_q;
	logic [31:0] rm_q, rs_q, rn_q, word_q, off_q, ea_q, addr_q, ld_q;
	logic        gpio_q, oob_q;
	logic [1:0]  out_status_q;
	logic [31:0] out_addr_q, out_ld_q;

	logic [RF_DEPTH-1:0] rf_valid_q;
	logic                rf_rd_valid_s1;
	logic [RF_AW-1:0]    rf_raddr, rf_waddr;
	logic [31:0]         rf_wdata, rf_rdata_raw, rf_rdata;
	logic [MEM_AW-1:0]   mem_raddr, mem_waddr;
	logic [7:0]          mem_wdata, mem_rdata;
	logic [7:0]          amt;
	logic [31:0]         off_next, ea_sum;

	// decode of the held item
	assign st.op         = op_q;
	assign st.pre        = ins_q[24];
	assign st.is_load    = ins_q[20];
	assign st.gpio       = gpio_q;
	assign st.oob        = oob_q;
	assign st.rf_idx_ok  = (idx_q[15:RF_AW] == '0);
	assign st.mem_idx_ok = (32'(idx_q) < 32'(MEM_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpio_low_q  <= 32'h2020_0000;
			gpio_high_q <= 32'h2020_0008;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_GPIO_LOW) begin
				gpio_low_q <= cfg_data;
			end else begin
				gpio_high_q <= cfg_data;
			end
		end
	end

	// register file: RAM plus valid bits, an entry never written reads as zero
	always_comb begin
		unique case (cmd.rf_rsel)
			RSEL_RM: rf_raddr = ins_q[3:0];
			RSEL_RS: rf_raddr = ins_q[11:8];
			RSEL_RN: rf_raddr = ins_q[19:16];
			default: rf_raddr = ins_q[15:12];
		endcase
		unique case (cmd.rf_wsel)
			WSEL_PRE: begin
				rf_waddr = idx_q[RF_AW-1:0];
				rf_wdata = data_q;
			end
			WSEL_GPIO: begin
				rf_waddr = ins_q[15:12];
				rf_wdata = addr_q;
			end
			WSEL_LOAD: begin
				rf_waddr = ins_q[15:12];
				rf_wdata = word_q;
			end
			default: begin
				rf_waddr = ins_q[19:16];
				rf_wdata = ea_q;
			end
		endcase
	end

	lsw_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf (
		.clk   (clk),
		.we    (cmd.rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (cmd.rf_re),
		.raddr (rf_raddr),
		.rdata (rf_rdata_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q     <= '0;
			rf_rd_valid_s1 <= 1'b0;
		end else begin
			if (cmd.rf_we) begin
				rf_valid_q[rf_waddr] <= 1'b1;
			end
			if (cmd.rf_re) begin
				rf_rd_valid_s1 <= rf_valid_q[rf_raddr];
			end
		end
	end

	assign rf_rdata = rf_rd_valid_s1 ? rf_rdata_raw : 32'd0;

	// byte memory
	assign mem_raddr = addr_q[MEM_AW-1:0] + MEM_AW'(cmd.byte_sel);

	always_comb begin
		unique case (cmd.mem_wsel)
			MSEL_CLEAR: begin
				mem_waddr = cmd.clr_addr;
				mem_wdata = 8'd0;
			end
			MSEL_PRE: begin
				mem_waddr = MEM_AW'(idx_q);
				mem_wdata = data_q[7:0];
			end
			default: begin
				mem_waddr = mem_raddr;
				mem_wdata = word_q[8*cmd.byte_sel +: 8];
			end
		endcase
	end

	lsw_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk   (clk),
		.we    (cmd.mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (cmd.mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// offset and effective address
	assign amt      = ins_q[4] ? rs_q[7:0] : {3'b000, ins_q[11:7]};
	assign off_next = ins_q[25] ? shift_op(ins_q[6:5], amt, rm_q) : {20'd0, ins_q[11:0]};
	assign ea_sum   = ins_q[23] ? (rn_q + off_q) : (rn_q - off_q);

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			op_q   <= s_tdata[1:0];
			ins_q  <= s_tdata[33:2];
			idx_q  <= s_tdata[49:34];
			data_q <= s_tdata[81:50];
			addr_q <= 32'd0;
			ld_q   <= 32'd0;
			gpio_q <= 1'b0;
			oob_q  <= 1'b0;
		end else begin
			if (cmd.addr_from_ea) begin
				addr_q <= ea_sum;
			end else if (cmd.addr_from_rn) begin
				addr_q <= rf_rdata;
			end
			if (cmd.check) begin
				gpio_q <= (gpio_low_q <= addr_q) && (addr_q <= gpio_high_q);
				oob_q  <= ({1'b0, addr_q} + 33'd3) >= 33'(MEM_BYTES);
			end
			if (cmd.rf_we && cmd.rf_wsel == WSEL_GPIO) begin
				ld_q <= addr_q;
			end else if (cmd.rf_we && cmd.rf_wsel == WSEL_LOAD) begin
				ld_q <= word_q;
			end
		end
		case (cmd.rf_cap)
			RCAP_RM:   rm_q   <= rf_rdata;
			RCAP_RS:   rs_q   <= rf_rdata;
			RCAP_RN:   rn_q   <= rf_rdata;
			RCAP_WORD: word_q <= rf_rdata;
			default:   ;
		endcase
		if (cmd.byte_cap) begin
			word_q[8*cmd.cap_sel +: 8] <= mem_rdata;
		end
		if (cmd.calc_off) begin
			off_q <= off_next;
		end
		if (cmd.calc_ea) begin
			ea_q <= ea_sum;
		end
		if (cmd.out_load) begin
			out_status_q <= gpio_q ? STAT_GPIO : (oob_q ? STAT_OOB : STAT_DONE);
			out_addr_q   <= addr_q;
			out_ld_q     <= ld_q;
		end
	end

	assign m_tdata = {6'd0, out_ld_q, out_addr_q, out_status_q};

endmodule

// File: hdl/lsw_ctrl.sv
// Controller of the load/store word unit: sequences register reads, the
// offset and address steps, byte transfers, writeback and the result word.
// Depends on lsw_pkg.
module lsw_ctrl
	import lsw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  lsw_stat_t st,
	output lsw_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_BASE_RD, ST_BASE_CAP,
		ST_RM_RD, ST_RS_RD, ST_RN_RD, ST_OFF, ST_EA, ST_CHECK, ST_XFER,
		ST_LD, ST_LD_FIN, ST_LD_WB, ST_ST_RD, ST_ST_CAP, ST_ST, ST_WB, ST_DONE
	} state_t;

	state_t            state_q, state_d;
	logic [1:0]        cnt_q;
	logic [MEM_AW-1:0] clr_q;
	logic              m_tvalid_q;
	logic              out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd          = '0;
		cmd.rf_rsel  = RSEL_RM;
		cmd.rf_cap   = RCAP_NONE;
		cmd.rf_wsel  = WSEL_PRE;
		cmd.mem_wsel = MSEL_CLEAR;
		cmd.byte_sel = cnt_q;
		cmd.cap_sel  = cnt_q - 2'd1;
		cmd.clr_addr = clr_q;
		state_d      = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.mem_we = 1'b1;
				if (clr_q == MEM_AW'(MEM_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.take_item = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (st.op == OP_XFER) begin
					state_d = st.pre ? ST_RM_RD : ST_BASE_RD;
				end else begin
					cmd.rf_wsel  = WSEL_PRE;
					cmd.rf_we    = (st.op == OP_WREG) && st.rf_idx_ok;
					cmd.mem_wsel = MSEL_PRE;
					cmd.mem_we   = (st.op == OP_WMEM) && st.mem_idx_ok;
					state_d      = ST_DONE;
				end
			end
			ST_BASE_RD: begin
				cmd.rf_re   = 1'b1;
				cmd.rf_rsel = RSEL_RN;
				state_d     = ST_BASE_CAP;
			end
			ST_BASE_CAP: begin
				cmd.addr_from_rn = 1'b1;
				state_d          = ST_CHECK;
			end
			ST_RM_RD: begin
				cmd.rf_re   = 1'b1;
				cmd.rf_rsel = RSEL_RM;
				state_d     = ST_RS_RD;
			end
			ST_RS_RD: begin
				cmd.rf_cap  = RCAP_RM;
				cmd.rf_re   = 1'b1;
				cmd.rf_rsel = RSEL_RS;
				state_d     = ST_RN_RD;
			end
			ST_RN_RD: begin
				cmd.rf_cap  = RCAP_RS;
				cmd.rf_re   = 1'b1;
				cmd.rf_rsel = RSEL_RN;
				state_d     = ST_OFF;
			end
			ST_OFF: begin
				cmd.rf_cap   = RCAP_RN;
				cmd.calc_off = 1'b1;
				state_d      = ST_EA;
			end
			ST_EA: begin
				cmd.calc_ea      = 1'b1;
				cmd.addr_from_ea = st.pre;
				state_d          = st.pre ? ST_CHECK : ST_WB;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_XFER;
			end
			ST_XFER: begin
				if (st.gpio) begin
					cmd.rf_we   = st.is_load;
					cmd.rf_wsel = WSEL_GPIO;
					state_d     = st.pre ? ST_DONE : ST_RM_RD;
				end else if (st.oob) begin
					state_d = st.pre ? ST_DONE : ST_RM_RD;
				end else begin
					state_d = st.is_load ? ST_LD : ST_ST_RD;
				end
			end
			ST_LD: begin
				cmd.mem_re   = 1'b1;
				cmd.byte_cap = (cnt_q != 2'd0);
				if (cnt_q == 2'd3) begin
					state_d = ST_LD_FIN;
				end
			end
			ST_LD_FIN: begin
				cmd.byte_cap = 1'b1;
				cmd.cap_sel  = 2'd3;
				state_d      = ST_LD_WB;
			end
			ST_LD_WB: begin
				cmd.rf_we   = 1'b1;
				cmd.rf_wsel = WSEL_LOAD;
				state_d     = st.pre ? ST_DONE : ST_RM_RD;
			end
			ST_ST_RD: begin
				cmd.rf_re   = 1'b1;
				cmd.rf_rsel = RSEL_RD;
				state_d     = ST_ST_CAP;
			end
			ST_ST_CAP: begin
				cmd.rf_cap = RCAP_WORD;
				state_d    = ST_ST;
			end
			ST_ST: begin
				cmd.mem_we   = 1'b1;
				cmd.mem_wsel = MSEL_STORE;
				if (cnt_q == 2'd3) begin
					state_d = st.pre ? ST_DONE : ST_RM_RD;
				end
			end
			ST_WB: begin
				cmd.rf_we   = 1'b1;
				cmd.rf_wsel = WSEL_EA;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				cmd.out_load = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= 2'd0;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + MEM_AW'(1);
			end
			if (state_q == ST_LD || state_q == ST_ST) begin
				cnt_q <= cnt_q + 2'd1;
			end else begin
				cnt_q <= 2'd0;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ST) |-> (!st.gpio && !st.oob))
		else $error("byte store issued for a window or out-of-range address");

	a_load_wb_is_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LD_WB) |-> st.is_load)
		else $error("load writeback for a store instruction");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (state_q != ST_CLEAR))
		else $error("result word pending during memory clear");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && m_tvalid_q && !m_tready) |=> (state_q == ST_DONE))
		else $error("result overwritten while receiver stalls");

endmodule

// File: hdl/load_store_word_unit.sv
// Top level of the load/store word unit: stream ports, configuration port,
// controller and datapath. Depends on lsw_pkg, lsw_ctrl and lsw_datapath.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata. Each carries an op: run a
//   word load or store instruction, preload one register, or preload one
//   memory byte. Every input word yields exactly one result word on
//   m_tvalid/m_tready/m_tdata (status, effective address, loaded word).
//   A transfer's run time is set by the single read port of the register file
//   (operands are fetched one per cycle) and the byte-wide data memory (four
//   accesses per word); a post-indexed transfer also writes back its base.
//   One word is in flight at a time.
//   After reset the data memory is swept to zero, one byte per cycle, over all
//   MEM_BYTES (65536) bytes; s_tready stays low during the sweep, while the
//   configuration port (cfg_wr_en, cfg_index, cfg_data) is taken at any time.
//   Configuration is expected only while the unit is idle.
//   The result sits in an output register: when the receiver stalls, the
//   unit still takes the next word and runs it up to its result, then holds.
module load_store_word_unit
	import lsw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// input word
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // op[1:0], instruction[33:2], index[49:34], data[81:50]
	// result word
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // status[1:0], address[33:2], load_data[65:34]
	// configuration writes: index 0 gpio_low, 1 gpio_high
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data
);

	lsw_cmd_t  cmd;
	lsw_stat_t st;

	// sequence the work
	lsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// hold state, compute addresses, move bytes
	lsw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.m_tdata   (m_tdata)
	);

endmodule
